FILE: rtl/mfc_pkg.sv
`default_nettype none
package mfc_pkg;

	// frame layout
	localparam int SAMPLES_PER_FRAME = 100;
	localparam int HEADER_BYTES      = 36;
	localparam int TRAILER_BYTES     = 12;
	localparam int BYTES_PER_SAMPLE  = 12;
	localparam int DATA_BYTES        = BYTES_PER_SAMPLE * SAMPLES_PER_FRAME;
	localparam int FRAME_BYTES       = HEADER_BYTES + DATA_BYTES + TRAILER_BYTES;
	localparam int POS_W             = $clog2(FRAME_BYTES);

	// field widths
	localparam int BYTE_W   = 8;
	localparam int AXIS_W   = 2;
	localparam int SAMPLE_W = 8;
	localparam int VALUE_W  = 32;
	localparam int HALF_W   = 16;
	localparam int SCALE_W  = 32;
	localparam int OFFS_W   = 48;
	localparam int PROD_W   = HALF_W + SCALE_W;
	localparam int CFG_IDX_W = 3;

	// fixed point: Q.28 sum to Q.8 result
	localparam int SCALE_FRAC = 28;
	localparam int OUT_FRAC   = 8;
	localparam int DROP_BITS  = SCALE_FRAC - OUT_FRAC;
	localparam int SUM_W      = 54;
	localparam int Q_W        = SUM_W - DROP_BITS;

	// stream widths
	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 48;

	typedef logic [AXIS_W-1:0] axis_t;

	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_DAC   = 3'd0,
		REG_X_ADC   = 3'd1,
		REG_Y_DAC   = 3'd2,
		REG_Y_ADC   = 3'd3,
		REG_Z_DAC   = 3'd4,
		REG_Z_ADC   = 3'd5,
		REG_OFFSETS = 3'd6
	} cfg_reg_t;

endpackage
`default_nettype wire

FILE: rtl/magnetometer_frame_converter.sv
`default_nettype none
// Magnetometer frame converter
// Input channel s_*: one frame byte per request in s_tdata, s_tuser high marks
// the byte as byte 0 of a frame (the byte counter restarts, any partial word is
// dropped). Without a marker the counter wraps by itself after the trailer.
// Output channel m_*: one converted axis value per completed 32-bit axis word,
// m_tlast high on the Z value of the final sample of a frame.
// Config port: cfg_we writes cfg_data into register cfg_index in the same
// clock edge; write only while no request is in flight.
// Throughput: one byte per cycle while s_tready is high; a result at most every fourth byte.
// The result of the fourth byte of a word reaches m_* through the input
// register, the multiplier register, and rounding and saturation into the
// output register.
// The three stages hold independently, so a stalled output blocks the input
// only once every stage carries a result; s_tready then drops.
// Reset clears the configuration, the valid flags and the frame position; the
// first byte after reset is frame byte 0.
module magnetometer_frame_converter (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [mfc_pkg::S_DATA_W-1:0] s_tdata,   // [7:0] data_byte
	input  wire logic                         s_tuser,   // [0] frame_start
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// [1:0] axis, [9:2] sample_index, [41:10] field_value, [47:42] zero
	output logic [mfc_pkg::M_DATA_W-1:0]      m_tdata,
	output logic                              m_tlast,   // last_value
	input  wire logic                         cfg_we,
	input  wire logic [mfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mfc_pkg::OFFS_W-1:0]   cfg_data
);
	import mfc_pkg::*;

	// configuration
	logic signed [SCALE_W-1:0] dac_scale_q [3];
	logic signed [SCALE_W-1:0] adc_scale_q [3];
	logic [OFFS_W-1:0]         offsets_q;

	// framing state
	logic [POS_W-1:0]    byte_pos_q;
	logic [23:0]         word_asm_q;
	logic [SAMPLE_W-1:0] sample_cnt_q;
	axis_t               axis_cnt_q;

	// stage 1: assembled word
	logic                v_s1;
	logic [31:0]         word_s1;
	axis_t               axis_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                last_s1;

	// stage 2: products
	logic                      v_s2;
	logic signed [PROD_W-1:0]  prod_d_s2;
	logic signed [PROD_W-1:0]  prod_a_s2;
	logic signed [HALF_W-1:0]  off_s2;
	axis_t                     axis_s2;
	logic [SAMPLE_W-1:0]       sample_s2;
	logic                      last_s2;

	// stage 3: output register
	logic                v_s3;
	axis_t               axis_s3;
	logic [SAMPLE_W-1:0] sample_s3;
	logic [VALUE_W-1:0]  value_s3;
	logic                last_s3;

	logic adv_s3, adv_s2, adv_s1, s_acc;

	// per-stage hand-off
	assign adv_s3   = !v_s3 || m_tready;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign s_tready = adv_s1;
	assign s_acc    = s_tvalid && s_tready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				dac_scale_q[i] <= '0;
				adc_scale_q[i] <= '0;
			end
			offsets_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_DAC:   dac_scale_q[0] <= cfg_data[SCALE_W-1:0];
				REG_X_ADC:   adc_scale_q[0] <= cfg_data[SCALE_W-1:0];
				REG_Y_DAC:   dac_scale_q[1] <= cfg_data[SCALE_W-1:0];
				REG_Y_ADC:   adc_scale_q[1] <= cfg_data[SCALE_W-1:0];
				REG_Z_DAC:   dac_scale_q[2] <= cfg_data[SCALE_W-1:0];
				REG_Z_ADC:   adc_scale_q[2] <= cfg_data[SCALE_W-1:0];
				REG_OFFSETS: offsets_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// byte position and word assembly
	logic [POS_W-1:0]    pos;
	logic [POS_W:0]      pos_inc;
	logic [POS_W-1:0]    pos_next;
	logic [POS_W-1:0]    data_off;
	logic                in_data, word_done, frame_restart;
	logic [23:0]         asm_cur;
	logic [SAMPLE_W-1:0] sample_cur;
	axis_t               axis_cur, axis_sel;

	always_comb begin
		pos = s_tuser ? '0 : byte_pos_q;
		if (32'(pos) >= FRAME_BYTES) begin
			pos = '0;
		end
		frame_restart = (pos == '0);
		asm_cur    = frame_restart ? '0 : word_asm_q;
		sample_cur = frame_restart ? '0 : sample_cnt_q;
		axis_cur   = frame_restart ? AXIS_X : axis_cnt_q;
		axis_sel   = (axis_cur > AXIS_Z) ? AXIS_Z : axis_cur;
		in_data    = (32'(pos) >= HEADER_BYTES) && (32'(pos) < HEADER_BYTES + DATA_BYTES);
		data_off   = pos - POS_W'(HEADER_BYTES);
		word_done  = in_data && (data_off[1:0] == 2'd3);
		pos_inc    = {1'b0, pos} + 1'b1;
		pos_next   = (32'(pos_inc) >= FRAME_BYTES) ? '0 : pos_inc[POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q   <= '0;
			word_asm_q   <= '0;
			sample_cnt_q <= '0;
			axis_cnt_q   <= AXIS_X;
		end else if (s_acc) begin
			byte_pos_q <= pos_next;
			if (in_data && !word_done) begin
				word_asm_q <= {asm_cur[15:0], s_tdata};
			end else begin
				word_asm_q <= asm_cur;
			end
			if (word_done && axis_sel == AXIS_Z) begin
				axis_cnt_q   <= AXIS_X;
				sample_cnt_q <= sample_cur + 1'b1;
			end else if (word_done) begin
				axis_cnt_q   <= axis_sel + 1'b1;
				sample_cnt_q <= sample_cur;
			end else begin
				axis_cnt_q   <= axis_cur;
				sample_cnt_q <= sample_cur;
			end
		end
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= s_acc && word_done;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			word_s1   <= {asm_cur, s_tdata};
			axis_s1   <= axis_sel;
			sample_s1 <= sample_cur;
			last_s1   <= (axis_sel == AXIS_Z) && (32'(sample_cur) == SAMPLES_PER_FRAME - 1);
		end
	end

	// scale multiplies
	logic signed [HALF_W-1:0]  dac_cnt, adc_cnt, off_sel;
	logic signed [SCALE_W-1:0] dac_sc, adc_sc;
	logic signed [PROD_W-1:0]  prod_d, prod_a;

	always_comb begin
		dac_cnt = word_s1[31:16];
		adc_cnt = word_s1[15:0];
		case (axis_s1)
			AXIS_X: begin
				dac_sc  = dac_scale_q[0];
				adc_sc  = adc_scale_q[0];
				off_sel = offsets_q[15:0];
			end
			AXIS_Y: begin
				dac_sc  = dac_scale_q[1];
				adc_sc  = adc_scale_q[1];
				off_sel = offsets_q[31:16];
			end
			default: begin
				dac_sc  = dac_scale_q[2];
				adc_sc  = adc_scale_q[2];
				off_sel = offsets_q[47:32];
			end
		endcase
		prod_d = dac_cnt * dac_sc;
		prod_a = adc_cnt * adc_sc;
	end

	// stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			prod_d_s2 <= prod_d;
			prod_a_s2 <= prod_a;
			off_s2    <= off_sel;
			axis_s2   <= axis_s1;
			sample_s2 <= sample_s1;
			last_s2   <= last_s1;
		end
	end

	// sum, round to nearest (ties up) and saturate
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (DROP_BITS - 1);
	localparam logic signed [Q_W-1:0]   Q_MAX = Q_W'(32'h7FFF_FFFF);
	localparam logic signed [Q_W-1:0]   Q_MIN = -Q_MAX - Q_W'(1);

	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  sum_sh;
	logic signed [Q_W-1:0]    q8;
	logic [VALUE_W-1:0]       value_sat;

	always_comb begin
		sum    = SUM_W'(prod_d_s2) + SUM_W'(prod_a_s2)
		       + (SUM_W'(off_s2) <<< SCALE_FRAC) + ROUND_HALF;
		sum_sh = sum >>> DROP_BITS;
		q8     = sum_sh[Q_W-1:0];
		if (q8 > Q_MAX) begin
			value_sat = Q_MAX[VALUE_W-1:0];
		end else if (q8 < Q_MIN) begin
			value_sat = Q_MIN[VALUE_W-1:0];
		end else begin
			value_sat = q8[VALUE_W-1:0];
		end
	end

	// stage 3: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			axis_s3   <= axis_s2;
			sample_s3 <= sample_s2;
			value_s3  <= value_sat;
			last_s3   <= last_s2;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {(M_DATA_W - AXIS_W - SAMPLE_W - VALUE_W)'(0), value_s3, sample_s3, axis_s3};
	assign m_tlast  = last_s3;

`ifndef SYNTHESIS
	// input stalls only when every stage holds a result
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3 && !m_tready))
		else $error("input stalled with a free stage");

	// frame position stays inside the frame
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(byte_pos_q) < FRAME_BYTES)
		else $error("byte position beyond frame");

	// last flag only on the Z value of the final sample
	a_last_z: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |->
		(axis_s3 == AXIS_Z && 32'(sample_s3) == SAMPLES_PER_FRAME - 1))
		else $error("last flag on wrong value");

	// no axis code beyond Z reaches the output
	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (axis_s3 == AXIS_X || axis_s3 == AXIS_Y || axis_s3 == AXIS_Z))
		else $error("bad axis code on output");

	// a completed word reaches stage 1 on the next edge
	a_word_load: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && word_done) |=> v_s1)
		else $error("completed word lost");
`endif

endmodule
`default_nettype wire
